// ===== design/wit_pkg.sv =====
`default_nettype none

package wit_pkg;

  // tile geometry
  localparam int TILE_DIM  = 6;
  localparam int TILE_SIZE = 36;
  localparam int POS_W     = 6;
  localparam int IDX_W     = 3;

  // coefficient port width
  localparam int COEFF_W = 23;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_DIM - 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TILE_SIZE - 1);

  // front -> tile buffer
  typedef struct packed {
    logic             we;
    logic             last;
    logic [POS_W-1:0] pos;
  } tile_wr_t;

  // back -> tile buffer
  typedef struct packed {
    logic             pop;
    logic [POS_W-1:0] pos;
  } tile_rd_t;

  // tile buffer status
  typedef struct packed {
    logic wr_full;
    logic rd_full;
  } q_stat_t;

  // row-major position of (row, col) in a 6x6 tile
  function automatic logic [POS_W-1:0] addr6(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
    logic [POS_W-1:0] r;
    r = {{(POS_W-IDX_W){1'b0}}, row};
    return (r << 2) + (r << 1) + {{(POS_W-IDX_W){1'b0}}, col};
  endfunction

endpackage

`default_nettype wire

// ===== design/winograd_f4x3_input_transform.sv =====
// Winograd F(4x4,3x3) input transform. Samples of a 6x6 tile enter in
// row-major order, one word per cycle whenever start is high and busy is
// low; in_image low turns a word into zero padding. A loaded tile is
// handed to the transform engine through a two-tile buffer, so the next
// tile loads while the previous one is transformed. The engine runs one
// shared 6-point unit over 12 passes (6 columns, then 6 rows), reading one
// stored word per cycle; the engine, not the loader, limits the sustained
// rate. busy rises only when both tile banks are held. The 36 exact
// coefficients come out in row-major order as one unbroken run, each
// marked by out_valid for one cycle, with out_last on the final one.
// The receiver cannot stall: every word on out_* must be taken in the
// cycle it is shown.
`default_nettype none

module winograd_f4x3_input_transform #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_image,
  output logic                                out_valid,
  output logic signed [wit_pkg::COEFF_W-1:0]  out_coeff,
  output logic [wit_pkg::IDX_W-1:0]           out_coeff_row,
  output logic [wit_pkg::IDX_W-1:0]           out_coeff_col,
  output logic                                out_last
);
  import wit_pkg::*;

  tile_wr_t                       tile_wr;
  tile_rd_t                       tile_rd;
  q_stat_t                        q_stat;
  logic signed [SAMPLE_WIDTH-1:0] tile_wdata;
  logic signed [SAMPLE_WIDTH-1:0] tile_rdata;

  // front: count the tile position, mask padding, write the buffer
  wit_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_sample  (in_sample),
    .in_image   (in_image),
    .q_stat     (q_stat),
    .tile_wr    (tile_wr),
    .tile_wdata (tile_wdata)
  );

  // two-bank tile queue between loader and engine
  wit_tile_buf #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_tile_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .tile_wr    (tile_wr),
    .tile_wdata (tile_wdata),
    .tile_rd    (tile_rd),
    .tile_rdata (tile_rdata),
    .q_stat     (q_stat)
  );

  // back: column pass, row pass, emit
  wit_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .tile_rd       (tile_rd),
    .tile_rdata    (tile_rdata),
    .out_valid     (out_valid),
    .out_coeff     (out_coeff),
    .out_coeff_row (out_coeff_row),
    .out_coeff_col (out_coeff_col),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== design/wit_front.sv =====
`default_nettype none

module wit_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_image,
  input  wit_pkg::q_stat_t               q_stat,
  output wit_pkg::tile_wr_t              tile_wr,
  output logic signed [SAMPLE_WIDTH-1:0] tile_wdata
);
  import wit_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept;

  // hold off while the bank being filled is still owned by the back end
  assign busy   = q_stat.wr_full;
  assign accept = start && !busy;

  assign tile_wr.we   = accept;
  assign tile_wr.last = accept && (pos_r == LAST_POS);
  assign tile_wr.pos  = pos_r;
  // padding samples enter as zero
  assign tile_wdata   = in_image ? in_sample : '0;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/wit_tile_buf.sv =====
`default_nettype none

module wit_tile_buf #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wit_pkg::tile_wr_t              tile_wr,
  input  logic signed [SAMPLE_WIDTH-1:0] tile_wdata,
  input  wit_pkg::tile_rd_t              tile_rd,
  output logic signed [SAMPLE_WIDTH-1:0] tile_rdata,
  output wit_pkg::q_stat_t               q_stat
);
  import wit_pkg::*;

  // two tile banks form a two-deep queue of tiles
  logic signed [SAMPLE_WIDTH-1:0] mem [2][TILE_SIZE];
  logic signed [SAMPLE_WIDTH-1:0] rdata_r;
  logic [1:0] full_r;
  logic       wr_bank_r;
  logic       rd_bank_r;

  assign q_stat.wr_full = full_r[wr_bank_r];
  assign q_stat.rd_full = full_r[rd_bank_r];
  assign tile_rdata     = rdata_r;

  always_ff @(posedge clk) begin
    if (tile_wr.we) begin
      mem[wr_bank_r][tile_wr.pos] <= tile_wdata;
    end
    rdata_r <= mem[rd_bank_r][tile_rd.pos];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r    <= '0;
      wr_bank_r <= 1'b0;
      rd_bank_r <= 1'b0;
    end else begin
      // push a complete tile
      if (tile_wr.last) begin
        full_r[wr_bank_r] <= 1'b1;
        wr_bank_r         <= !wr_bank_r;
      end
      // release the bank once its last word is read
      if (tile_rd.pop) begin
        full_r[rd_bank_r] <= 1'b0;
        rd_bank_r         <= !rd_bank_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wit_back.sv =====
`default_nettype none

module wit_back #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wit_pkg::q_stat_t                     q_stat,
  output wit_pkg::tile_rd_t                    tile_rd,
  input  logic signed [SAMPLE_WIDTH-1:0]       tile_rdata,
  output logic                                 out_valid,
  output logic signed [wit_pkg::COEFF_W-1:0]   out_coeff,
  output logic [wit_pkg::IDX_W-1:0]            out_coeff_row,
  output logic [wit_pkg::IDX_W-1:0]            out_coeff_col,
  output logic                                 out_last
);
  import wit_pkg::*;

  localparam int CW = SAMPLE_WIDTH + 4;  // column pass result
  localparam int YW = SAMPLE_WIDTH + 8;  // row pass result

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COL  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_ROW  = 4'b1000
  } bk_state_t;

  bk_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] grp_r, grp_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             issue, grp_end, pass_end, pipe_busy;

  // read stage
  logic             rd_v_r, rd_row_r, rd_lst_r;
  logic [IDX_W-1:0] rd_grp_r;
  logic signed [CW-1:0] x_in;

  // gather and compute stage
  logic signed [CW-1:0] x_r [TILE_DIM];
  logic                 calc_v_r, calc_row_r;
  logic [IDX_W-1:0]     calc_grp_r;
  logic signed [YW-1:0] xe  [TILE_DIM];
  logic signed [YW-1:0] y_c [TILE_DIM];
  logic signed [YW-1:0] d42, d13;

  // drain stage
  logic signed [YW-1:0] y_r [TILE_DIM];
  logic                 dr_act_r, dr_row_r;
  logic [IDX_W-1:0]     dr_cnt_r, dr_grp_r;

  // column pass store
  logic signed [CW-1:0] cs_mem [TILE_SIZE];
  logic signed [CW-1:0] cs_rdata_r;

  // output register
  logic                       out_valid_r, out_last_r;
  logic signed [COEFF_W-1:0]  out_coeff_r, coeff_sat;
  logic [IDX_W-1:0]           out_row_r, out_col_r;

  // ---------------- sequencer ----------------
  assign issue     = (state_r == ST_COL) || (state_r == ST_ROW);
  assign grp_end   = (idx_r == LAST_IDX);
  assign pass_end  = grp_end && (grp_r == LAST_IDX);
  assign pipe_busy = rd_v_r || calc_v_r || dr_act_r;

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    idx_nxt   = idx_r;
    if (issue) begin
      if (grp_end) begin
        idx_nxt = '0;
        grp_nxt = pass_end ? '0 : grp_r + 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (q_stat.rd_full) state_nxt = ST_COL;
      end
      ST_COL: begin
        if (pass_end) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        // row pass may start only once every column result is stored
        if (!pipe_busy) state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (pass_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // column pass walks down a column of the tile
  assign tile_rd.pos = addr6(idx_r, grp_r);
  assign tile_rd.pop = (state_r == ST_COL) && pass_end;

  // ---------------- read stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
    end
    rd_row_r <= (state_r == ST_ROW);
    rd_lst_r <= grp_end;
    rd_grp_r <= grp_r;
  end

  assign x_in = rd_row_r ? cs_rdata_r
                         : {{(CW-SAMPLE_WIDTH){tile_rdata[SAMPLE_WIDTH-1]}}, tile_rdata};

  // ---------------- gather and 6-point unit ----------------
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      for (int k = 0; k < TILE_DIM - 1; k++) begin
        x_r[k] <= x_r[k+1];
      end
      x_r[TILE_DIM-1] <= x_in;
      calc_row_r      <= rd_row_r;
      calc_grp_r      <= rd_grp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_v_r <= 1'b0;
    end else begin
      calc_v_r <= rd_v_r && rd_lst_r;
    end
  end

  always_comb begin
    for (int k = 0; k < TILE_DIM; k++) begin
      xe[k] = {{(YW-CW){x_r[k][CW-1]}}, x_r[k]};
    end
    d42    = xe[4] - xe[2];
    d13    = xe[1] - xe[3];
    y_c[0] = ((xe[0] - xe[2]) <<< 2) + d42;
    y_c[1] = (xe[3] + xe[4]) - ((xe[1] + xe[2]) <<< 2);
    y_c[2] = ((xe[1] - xe[2]) <<< 2) + (xe[4] - xe[3]);
    y_c[3] = d42 - (d13 <<< 1);
    y_c[4] = (d13 <<< 1) + d42;
    y_c[5] = (d13 <<< 2) + (xe[5] - xe[3]);
  end

  // ---------------- drain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_act_r <= 1'b0;
      dr_cnt_r <= '0;
    end else if (calc_v_r) begin
      dr_act_r <= 1'b1;
      dr_cnt_r <= '0;
    end else if (dr_act_r) begin
      if (dr_cnt_r == LAST_IDX) begin
        dr_act_r <= 1'b0;
      end
      dr_cnt_r <= dr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_v_r) begin
      for (int k = 0; k < TILE_DIM; k++) begin
        y_r[k] <= y_c[k];
      end
      dr_row_r <= calc_row_r;
      dr_grp_r <= calc_grp_r;
    end else if (dr_act_r) begin
      for (int k = 0; k < TILE_DIM - 1; k++) begin
        y_r[k] <= y_r[k+1];
      end
    end
  end

  // ---------------- column pass store ----------------
  always_ff @(posedge clk) begin
    if (dr_act_r && !dr_row_r) begin
      cs_mem[addr6(dr_cnt_r, dr_grp_r)] <= y_r[0][CW-1:0];
    end
    if (state_r == ST_ROW) begin
      cs_rdata_r <= cs_mem[addr6(grp_r, idx_r)];
    end
  end

  // ---------------- saturate and emit ----------------
  generate
    if (YW > COEFF_W) begin : g_sat
      logic [YW-COEFF_W:0] hi;
      assign hi = y_r[0][YW-1:COEFF_W-1];
      assign coeff_sat = ((&hi) || !(|hi)) ? y_r[0][COEFF_W-1:0]
                       : (y_r[0][YW-1] ? {1'b1, {(COEFF_W-1){1'b0}}}
                                       : {1'b0, {(COEFF_W-1){1'b1}}});
    end else if (YW == COEFF_W) begin : g_eq
      assign coeff_sat = y_r[0];
    end else begin : g_ext
      assign coeff_sat = {{(COEFF_W-YW){y_r[0][YW-1]}}, y_r[0]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dr_act_r && dr_row_r;
    end
    out_coeff_r <= coeff_sat;
    out_row_r   <= dr_grp_r;
    out_col_r   <= dr_cnt_r;
    out_last_r  <= (dr_grp_r == LAST_IDX) && (dr_cnt_r == LAST_IDX);
  end

  assign out_valid     = out_valid_r;
  assign out_coeff     = out_coeff_r;
  assign out_coeff_row = out_row_r;
  assign out_coeff_col = out_col_r;
  assign out_last      = out_last_r && out_valid_r;

endmodule

`default_nettype wire

// ===== design/wit_chk.sv =====
`default_nettype none

module wit_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [wit_pkg::COEFF_W-1:0]  out_coeff,
  input logic [wit_pkg::IDX_W-1:0]           out_coeff_row,
  input logic [wit_pkg::IDX_W-1:0]           out_coeff_col,
  input logic                                out_last
);
  import wit_pkg::*;

  localparam logic signed [COEFF_W-1:0] COEFF_MAX = COEFF_W'(3276800);
  localparam logic signed [COEFF_W-1:0] COEFF_MIN = -COEFF_W'(3276800);

  // reset leaves no word on the output and the loader open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("output or busy active after reset");

  // the final word of a tile sits at the bottom right corner
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_coeff_row == LAST_IDX && out_coeff_col == LAST_IDX)
    else $error("last flag off the final coefficient");

  // a row is emitted as one unbroken burst
  a_row_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coeff_col != LAST_IDX |=>
      out_valid && out_coeff_row == $past(out_coeff_row)
      && out_coeff_col == $past(out_coeff_col) + 1'b1)
    else $error("row burst broken");

  // indexes stay inside the 6x6 result
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coeff_row <= LAST_IDX && out_coeff_col <= LAST_IDX)
    else $error("coefficient index out of range");

  // with 16-bit samples every coefficient stays within its exact bound
  a_coeff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> SAMPLE_WIDTH != 16
      || (out_coeff <= COEFF_MAX && out_coeff >= COEFF_MIN))
    else $error("coefficient outside exact bound");

endmodule

bind winograd_f4x3_input_transform wit_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wit_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_coeff     (out_coeff),
  .out_coeff_row (out_coeff_row),
  .out_coeff_col (out_coeff_col),
  .out_last      (out_last)
);

`default_nettype wire
